// ===== hw/rtl/wrp_pkg.sv =====
package wrp_pkg;

  // One input word: a file byte and its end-of-file mark.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] chunk_tag;
    logic [3:0]  field_id;
    logic [63:0] value;
    logic [1:0]  error_code;
    logic        is_last;
  } result_t;

  // What one accepted byte leaves for the back end: an optional result of its own and an
  // optional end-of-file verdict that follows it.
  typedef struct packed {
    logic    main_valid;
    result_t main_res;
    logic    final_valid;
    logic    final_ok;
  } job_t;

  // Event codes.
  localparam logic [2:0] EV_RIFF  = 3'd0;
  localparam logic [2:0] EV_CHUNK = 3'd1;
  localparam logic [2:0] EV_FIELD = 3'd2;
  localparam logic [2:0] EV_DATA  = 3'd3;
  localparam logic [2:0] EV_END   = 3'd4;
  localparam logic [2:0] EV_ERROR = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_RIFF = 2'd1;
  localparam logic [1:0] ERR_NO_WAVE = 2'd2;
  localparam logic [1:0] ERR_NO_DATA = 2'd3;

  // Chunk tags, first byte most significant.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_FACT = 32'h6661_6374;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Field identifiers that the parser treats specially.
  localparam logic [3:0] FID_NONE  = 4'd0;
  localparam logic [3:0] FID_EXT   = 4'd6;
  localparam logic [3:0] FID_VALID = 4'd7;
  localparam logic [3:0] FID_FACT  = 4'd11;

  // Format body offsets from this one on are skipped; size limits for the optional fields.
  localparam logic [5:0]  FMT_END      = 6'd40;
  localparam logic [31:0] FMT_BASIC    = 32'd16;
  localparam logic [31:0] FMT_EXTENDED = 32'd18;
  localparam logic [63:0] HEADER_BYTES = 64'd8;

  // Position of a format body byte within its field.
  typedef struct packed {
    logic [3:0] id;
    logic [2:0] off;
    logic       last;
  } fmt_slot_t;

  // Format body layout: which field a byte at offset pos (below 40) belongs to.
  function automatic fmt_slot_t fmt_slot(input logic [5:0] pos);
    fmt_slot_t  s;
    logic [5:0] start;
    logic [3:0] len;
    s = '0;
    if (pos < 6'd2) begin
      s.id = 4'd0; start = 6'd0; len = 4'd2;
    end else if (pos < 6'd4) begin
      s.id = 4'd1; start = 6'd2; len = 4'd2;
    end else if (pos < 6'd8) begin
      s.id = 4'd2; start = 6'd4; len = 4'd4;
    end else if (pos < 6'd12) begin
      s.id = 4'd3; start = 6'd8; len = 4'd4;
    end else if (pos < 6'd14) begin
      s.id = 4'd4; start = 6'd12; len = 4'd2;
    end else if (pos < 6'd16) begin
      s.id = 4'd5; start = 6'd14; len = 4'd2;
    end else if (pos < 6'd18) begin
      s.id = 4'd6; start = 6'd16; len = 4'd2;
    end else if (pos < 6'd20) begin
      s.id = 4'd7; start = 6'd18; len = 4'd2;
    end else if (pos < 6'd24) begin
      s.id = 4'd8; start = 6'd20; len = 4'd4;
    end else if (pos < 6'd32) begin
      s.id = 4'd9; start = 6'd24; len = 4'd8;
    end else begin
      s.id = 4'd10; start = 6'd32; len = 4'd8;
    end
    s.off  = 3'(pos - start);
    s.last = ({1'b0, s.off} == (len - 4'd1));
    return s;
  endfunction

  // Assemble a result word.
  function automatic result_t mk_result(input logic [2:0] ev, input logic [31:0] tag,
                                        input logic [3:0] fid, input logic [63:0] val,
                                        input logic [1:0] err, input logic last);
    result_t r;
    r.event_res  = ev;
    r.chunk_tag  = tag;
    r.field_id   = fid;
    r.value      = val;
    r.error_code = err;
    r.is_last    = last;
    return r;
  endfunction

  // The end-of-file verdict: success if a data chunk was seen, otherwise an error.
  function automatic result_t final_result(input logic ok);
    return mk_result(ok ? EV_END : EV_ERROR, 32'd0, FID_NONE, 64'd0,
                     ok ? ERR_NONE : ERR_NO_DATA, 1'b1);
  endfunction

endpackage

// ===== hw/rtl/wrp_front.sv =====
module wrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  wrp_pkg::item_t    item,
  output logic              job_valid,
  output wrp_pkg::job_t     job
);

  typedef enum logic [3:0] {
    PH_RIFF_TAG,
    PH_RIFF_LEN,
    PH_WAVE,
    PH_TAG,
    PH_LEN,
    PH_FMT,
    PH_FACT,
    PH_DATA,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [5:0]  byte_count, byte_count_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [63:0] value_accum, value_accum_next;
  logic        fmt_gt16, fmt_gt16_next;
  logic        fmt_gt18, fmt_gt18_next;
  logic        data_seen, data_seen_next;
  logic        halted, halted_next;

  logic [1:0]          k;
  logic [31:0]         tag_new;
  logic [31:0]         len_new;
  logic [63:0]         fmt_acc;
  logic [63:0]         fact_acc;
  logic [31:0]         rem_dec;
  logic                body_done;
  logic                fmt_allowed;
  wrp_pkg::fmt_slot_t  slot;

  // Byte-lane accumulators and counters used by the phases.
  always_comb begin
    k        = byte_count[1:0];
    tag_new  = {tag_shift[23:0], item.byte_in};
    len_new  = (k == 2'd0) ? 32'd0 : value_accum[31:0];
    len_new[{k, 3'b000} +: 8] = item.byte_in;
    slot     = wrp_pkg::fmt_slot(byte_count);
    fmt_acc  = (slot.off == 3'd0) ? 64'd0 : value_accum;
    fmt_acc[{slot.off, 3'b000} +: 8] = item.byte_in;
    fact_acc = (byte_count[1:0] == 2'd0) ? 64'd0 : value_accum;
    fact_acc[{byte_count[1:0], 3'b000} +: 8] = item.byte_in;
    rem_dec  = chunk_remaining - 32'd1;
    body_done = (rem_dec == 32'd0);
    if (slot.id == wrp_pkg::FID_EXT) begin
      fmt_allowed = fmt_gt16;
    end else if (slot.id >= wrp_pkg::FID_VALID) begin
      fmt_allowed = fmt_gt18;
    end else begin
      fmt_allowed = 1'b1;
    end
  end

  // Parser next state and the job that the byte produces.
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    chunk_remaining_next = chunk_remaining;
    tag_shift_next       = tag_shift;
    value_accum_next     = value_accum;
    fmt_gt16_next        = fmt_gt16;
    fmt_gt18_next        = fmt_gt18;
    data_seen_next       = data_seen;
    halted_next          = halted;
    job                  = '0;

    if (!halted) begin
      unique case (phase)
        PH_RIFF_TAG, PH_WAVE, PH_TAG: begin
          tag_shift_next  = tag_new;
          byte_count_next = 6'(k) + 6'd1;
          if (k == 2'd3) begin
            byte_count_next  = 6'd0;
            value_accum_next = 64'd0;
            if (phase == PH_RIFF_TAG) begin
              if (tag_new != wrp_pkg::TAG_RIFF) begin
                job.main_valid = 1'b1;
                job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_ERROR, 32'd0,
                                   wrp_pkg::FID_NONE, 64'd0, wrp_pkg::ERR_NO_RIFF, 1'b1);
                halted_next    = 1'b1;
              end else begin
                phase_next = PH_RIFF_LEN;
              end
            end else if (phase == PH_WAVE) begin
              if (tag_new != wrp_pkg::TAG_WAVE) begin
                job.main_valid = 1'b1;
                job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_ERROR, 32'd0,
                                   wrp_pkg::FID_NONE, 64'd0, wrp_pkg::ERR_NO_WAVE, 1'b1);
                halted_next    = 1'b1;
              end else begin
                phase_next = PH_TAG;
              end
            end else if (tag_new == wrp_pkg::TAG_DATA && data_seen) begin
              // A second data chunk closes the file successfully.
              job.main_valid = 1'b1;
              job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_END, 32'd0,
                                 wrp_pkg::FID_NONE, 64'd0, wrp_pkg::ERR_NONE, 1'b1);
              halted_next    = 1'b1;
            end else begin
              phase_next = PH_LEN;
            end
          end
        end
        PH_RIFF_LEN, PH_LEN: begin
          value_accum_next = {32'd0, len_new};
          byte_count_next  = 6'(k) + 6'd1;
          if (k == 2'd3) begin
            byte_count_next = 6'd0;
            job.main_valid  = 1'b1;
            job.main_res    = wrp_pkg::mk_result(
                                (phase == PH_RIFF_LEN) ? wrp_pkg::EV_RIFF : wrp_pkg::EV_CHUNK,
                                tag_shift, wrp_pkg::FID_NONE,
                                {32'd0, len_new} + wrp_pkg::HEADER_BYTES,
                                wrp_pkg::ERR_NONE, 1'b0);
            if (phase == PH_RIFF_LEN) begin
              phase_next = PH_WAVE;
            end else begin
              chunk_remaining_next = len_new;
              value_accum_next     = 64'd0;
              if (tag_shift == wrp_pkg::TAG_FMT) begin
                fmt_gt16_next = (len_new > wrp_pkg::FMT_BASIC);
                fmt_gt18_next = (len_new > wrp_pkg::FMT_EXTENDED);
                phase_next    = PH_FMT;
              end else if (tag_shift == wrp_pkg::TAG_FACT) begin
                phase_next = PH_FACT;
              end else if (tag_shift == wrp_pkg::TAG_DATA) begin
                data_seen_next = 1'b1;
                phase_next     = PH_DATA;
              end else begin
                phase_next = PH_SKIP;
              end
              // An empty body goes straight on to the next header.
              if (len_new == 32'd0) begin
                phase_next = PH_TAG;
              end
            end
          end
        end
        PH_FMT: begin
          if (byte_count < wrp_pkg::FMT_END) begin
            value_accum_next = fmt_acc;
            if (slot.last && fmt_allowed) begin
              job.main_valid = 1'b1;
              job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_FIELD, tag_shift, slot.id,
                                                  fmt_acc, wrp_pkg::ERR_NONE, 1'b0);
            end
          end
          if (byte_count != wrp_pkg::FMT_END) begin
            byte_count_next = byte_count + 6'd1;
          end
          chunk_remaining_next = rem_dec;
          if (body_done) begin
            phase_next       = PH_TAG;
            byte_count_next  = 6'd0;
            value_accum_next = 64'd0;
          end
        end
        PH_FACT: begin
          if (byte_count < 6'd4) begin
            value_accum_next = fact_acc;
            if (byte_count == 6'd3) begin
              job.main_valid = 1'b1;
              job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_FIELD, tag_shift,
                                 wrp_pkg::FID_FACT, fact_acc, wrp_pkg::ERR_NONE, 1'b0);
            end
          end
          if (byte_count != wrp_pkg::FMT_END) begin
            byte_count_next = byte_count + 6'd1;
          end
          chunk_remaining_next = rem_dec;
          if (body_done) begin
            phase_next       = PH_TAG;
            byte_count_next  = 6'd0;
            value_accum_next = 64'd0;
          end
        end
        PH_DATA: begin
          job.main_valid = 1'b1;
          job.main_res   = wrp_pkg::mk_result(wrp_pkg::EV_DATA, tag_shift, wrp_pkg::FID_NONE,
                                              {56'd0, item.byte_in}, wrp_pkg::ERR_NONE, 1'b0);
          chunk_remaining_next = rem_dec;
          if (body_done) begin
            phase_next       = PH_TAG;
            byte_count_next  = 6'd0;
            value_accum_next = 64'd0;
          end
        end
        PH_SKIP: begin
          chunk_remaining_next = rem_dec;
          if (body_done) begin
            phase_next       = PH_TAG;
            byte_count_next  = 6'd0;
            value_accum_next = 64'd0;
          end
        end
        default: begin
          phase_next           = PH_RIFF_TAG;
          byte_count_next      = 6'd0;
          chunk_remaining_next = 32'd0;
          tag_shift_next       = 32'd0;
          value_accum_next     = 64'd0;
          fmt_gt16_next        = 1'b0;
          fmt_gt18_next        = 1'b0;
          data_seen_next       = 1'b0;
        end
      endcase
    end

    // The last byte of a file brings the verdict, unless parsing has already halted,
    // and readies the parser for the next file.
    if (item.end_of_file) begin
      if (!halted_next) begin
        job.final_valid = 1'b1;
        job.final_ok    = data_seen_next;
      end
      phase_next           = PH_RIFF_TAG;
      byte_count_next      = 6'd0;
      chunk_remaining_next = 32'd0;
      tag_shift_next       = 32'd0;
      value_accum_next     = 64'd0;
      fmt_gt16_next        = 1'b0;
      fmt_gt18_next        = 1'b0;
      data_seen_next       = 1'b0;
      halted_next          = 1'b0;
    end
  end

  assign job_valid = accept && (job.main_valid || job.final_valid);

  // Parser state, advanced once for each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF_TAG;
      byte_count      <= 6'd0;
      chunk_remaining <= 32'd0;
      tag_shift       <= 32'd0;
      value_accum     <= 64'd0;
      fmt_gt16        <= 1'b0;
      fmt_gt18        <= 1'b0;
      data_seen       <= 1'b0;
      halted          <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      chunk_remaining <= chunk_remaining_next;
      tag_shift       <= tag_shift_next;
      value_accum     <= value_accum_next;
      fmt_gt16        <= fmt_gt16_next;
      fmt_gt18        <= fmt_gt18_next;
      data_seen       <= data_seen_next;
      halted          <= halted_next;
    end
  end

  // A result that closes the file is never followed by a second verdict.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.main_valid && job.main_res.is_last) |-> !job.final_valid)
    else $error("closing result followed by a verdict");

endmodule

// ===== hw/rtl/wrp_queue.sv =====
module wrp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  wrp_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output wrp_pkg::job_t rd_job,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wrp_pkg::job_t     mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a write");

endmodule

// ===== hw/rtl/wrp_back.sv =====
module wrp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  wrp_pkg::job_t    q_job,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output wrp_pkg::result_t result
);

  logic              out_valid;
  wrp_pkg::result_t  out_word;
  logic              pend;
  logic              pend_ok;
  logic              popped;
  logic              load;

  assign popped = pop && out_valid;
  assign load   = !q_empty && !pend && (!out_valid || popped);
  assign q_pop  = load;
  assign empty  = !out_valid;
  assign result = out_word;

  // Output register: a job's own result first, then its end-of-file verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (pend && popped) begin
      out_word  <= wrp_pkg::final_result(pend_ok);
      pend      <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      if (q_job.main_valid) begin
        out_word <= q_job.main_res;
        pend     <= q_job.final_valid;
        pend_ok  <= q_job.final_ok;
      end else begin
        out_word <= wrp_pkg::final_result(q_job.final_ok);
      end
    end else if (popped) begin
      out_valid <= 1'b0;
    end
  end

  a_pend_shown: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_valid)
    else $error("verdict waiting without a result on show");

  a_pend_not_last: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_word.is_last)
    else $error("verdict waiting behind a closing result");

endmodule

// ===== hw/rtl/wav_riff_stream_parser.sv =====
// A byte's job enters the job queue at the edge that accepts the byte and moves into the output
// register once that register is free; an end-of-file verdict that follows a result of the same
// byte comes up in the cycle after that result is taken. Throughput: one byte per cycle while
// the queue is not full, set by the single-pass parser; a byte that yields two words holds the
// output register until both are taken, absorbed by the queue. Reset: synchronous, active high;
// it returns the parser to the RIFF tag, empties the job queue and clears the output register.
module wav_riff_stream_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  wrp_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output wrp_pkg::result_t result
);

  logic          accept;
  logic          job_valid;
  wrp_pkg::job_t job;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  wrp_pkg::job_t q_job;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Front end: parses each byte and classifies what it yields.
  wrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  // Job queue between the parser and the output side.
  wrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  // Back end: expands jobs into result words.
  wrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
